// File: rtl/ssvgp_pkg.sv
// Package for the spatial voice gain, pan and Doppler block.
// Holds the configuration struct, register indexes, controller states and
// the command/status types shared by the controller and the datapath.
package ssvgp_pkg;

	localparam logic [16:0] SPEED_Q8 = 17'd87808;
	localparam logic [31:0] SPEED_SHIFTED = 32'd1438646272;

	typedef struct packed {
		logic [12:0] ref_dist;
		logic [16:0] max_dist;
		logic [16:0] volume;
		logic [14:0] panning_amount;
		logic [16:0] doppler_amount;
		logic [14:0] hop_transmission;
		logic [16:0] base_pitch;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_REFERENCE,
		REG_MAX_DISTANCE,
		REG_VOLUME,
		REG_PANNING,
		REG_DOPPLER,
		REG_HOP_TRANSMISSION,
		REG_BASE_PITCH
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_G0_GO, OP_G0_WAIT, OP_T_GO, OP_T_WAIT, OP_T2, OP_T4, OP_G,
		OP_VOL, OP_HOP, OP_PAN, OP_X2, OP_R1, OP_R2, OP_R3, OP_S, OP_GAIN,
		OP_CLOSE, OP_TERM, OP_F_GO, OP_F_WAIT, OP_PITCH
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_G0_GO, ST_G0_WAIT, ST_T_GO, ST_T_WAIT, ST_T2, ST_T4, ST_G,
		ST_VOL, ST_HOP, ST_PAN, ST_X2, ST_R1, ST_R2, ST_R3, ST_S, ST_GAIN,
		ST_CLOSE, ST_TERM, ST_F_GO, ST_F_WAIT, ST_PITCH, ST_DONE
	} st_t;

	typedef struct packed {
		op_t  op;
		logic chan;
		logic load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

endpackage

// File: rtl/spatial_voice_gain_pan_doppler.sv
// Top level of the spatial voice gain, pan and Doppler block.
// Depends on ssvgp_pkg, ssvgp_ctrl and ssvgp_dp (which holds ssvgp_div).
//
// Usage: one input transfer on the s_ side carries a frame's path distance,
// previous distance, hop count and side cosine; one output transfer on the
// m_ side returns the left gain, right gain and pitch for that frame.
// Configuration registers are written on the cfg_ channel, which is always
// ready; the user must write them only while the block is idle, as the
// block itself does not enforce this. When the output register is free,
// the time from input transfer to m_tvalid is dominated by three divisions
// on the shared restoring divider, plus 21 multiply steps on the shared
// multiplier and the load of the output register. One item is in work at
// a time; s_tready is high only while the controller is idle, so a new
// item is taken only once the last one is in the output register.
// A finished result sits in the output register, so the next item is taken
// while m_tvalid waits on m_tready; a stalled receiver holds the block in
// its final step only when a second result is ready before the first is
// taken. Reset clears the registers to their defaults and marks that no
// frame has been seen, so the first frame after reset gets no Doppler.
module spatial_voice_gain_pan_doppler import ssvgp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// path_distance[17:0], previous_distance[35:18], hop_count[36],
	// side_cosine[52:37], zero fill[55:53]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// gain_left[16:0], gain_right[33:17], pitch_out[51:34], zero fill[55:52]
	output logic [55:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	cfg_t        cfg_q;
	cmd_t        cmd;
	stat_t       stat;
	logic [16:0] gain_left, gain_right;
	logic [17:0] pitch_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_dist         <= 13'd256;
			cfg_q.max_dist         <= 17'd12800;
			cfg_q.volume           <= 17'd16384;
			cfg_q.panning_amount   <= 15'd16384;
			cfg_q.doppler_amount   <= 17'd16384;
			cfg_q.hop_transmission <= 15'd16384;
			cfg_q.base_pitch       <= 17'd16384;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_REFERENCE:        cfg_q.ref_dist <= cfg_data[12:0];
				REG_MAX_DISTANCE:     cfg_q.max_dist <= cfg_data;
				REG_VOLUME:           cfg_q.volume <= cfg_data;
				REG_PANNING:          cfg_q.panning_amount <= cfg_data[14:0];
				REG_DOPPLER:          cfg_q.doppler_amount <= cfg_data;
				REG_HOP_TRANSMISSION: cfg_q.hop_transmission <= cfg_data[14:0];
				REG_BASE_PITCH:       cfg_q.base_pitch <= cfg_data;
				default: ;
			endcase
		end
	end

	ssvgp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssvgp_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.cmd               (cmd),
		.stat              (stat),
		.path_distance     (s_tdata[17:0]),
		.previous_distance (s_tdata[35:18]),
		.hop_count         (s_tdata[36]),
		.side_cosine       (s_tdata[52:37]),
		.gain_left         (gain_left),
		.gain_right        (gain_right),
		.pitch_out         (pitch_out)
	);

	assign m_tdata = {4'b0, pitch_out, gain_right, gain_left};

	// The block holds one item at a time: right after a transfer it is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[51:34] >= 18'd2048 && m_tdata[51:34] <= 18'd131072))
		else $error("pitch outside its saturation range");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] <= 17'd65536 && m_tdata[33:17] <= 17'd65536))
		else $error("gain outside its saturation range");

endmodule

// File: rtl/ssvgp_div.sv
// Restoring divider, one quotient bit per cycle, 32 steps.
// Stands alone; ssvgp_dp uses it for the three divisions of an item.
module ssvgp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [27:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [27:0] rem_q;
	logic [27:0] dvs_q;
	logic [31:0] quo_q;
	logic [28:0] rem_sh;
	logic [28:0] rem_sub;
	logic        fits;

	assign rem_sh  = {rem_q, quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign fits    = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 28'd0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[27:0] : rem_sh[27:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/ssvgp_dp.sv
// Datapath: operand registers, one shared multiplier and the shared divider.
// Depends on ssvgp_pkg and ssvgp_div; sequenced by ssvgp_ctrl commands.
module ssvgp_dp import ssvgp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [17:0]        path_distance,
	input  logic [17:0]        previous_distance,
	input  logic               hop_count,
	input  logic signed [15:0] side_cosine,
	output logic [16:0]        gain_left,
	output logic [16:0]        gain_right,
	output logic [17:0]        pitch_out
);

	logic [17:0]        d_q, prev_q;
	logic               hop_q;
	logic signed [15:0] side_q;
	logic               seen_q, dop_en_q;
	logic [14:0]        g0_q, t_q, t2_q, win_q, p_q, x2_q, r_q, s_q;
	logic [17:0]        g_q;
	logic [16:0]        gl_q, gr_q;
	logic signed [25:0] closing_q;
	logic [26:0]        den_q;
	logic [15:0]        f_q;
	logic [17:0]        pitch_q;
	logic [16:0]        gl_out_q, gr_out_q;
	logic [17:0]        pitch_out_q;

	logic [12:0]        ref_w;
	logic [16:0]        maxd_w;
	logic [17:0]        dd_w;
	logic               far_w;
	logic [14:0]        x_w;
	logic [18:0]        diff_w;
	logic signed [25:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [44:0] prod_w, sh_w, trunc_w, den_w;
	logic signed [16:0] pan_c;
	logic [16:0]        psum;
	logic [18:0]        gain_w;
	logic [17:0]        pv;
	logic               div_start;
	logic [31:0]        div_dividend, quo;
	logic [27:0]        div_divisor;
	logic               div_done;

	assign ref_w  = (cfg.ref_dist == 13'd0) ? 13'd1 : cfg.ref_dist;
	assign maxd_w = (cfg.max_dist > {4'b0, ref_w}) ? cfg.max_dist
	                                                : {4'b0, ref_w} + 17'd1;
	assign far_w  = d_q >= {1'b0, maxd_w};
	assign dd_w   = (d_q > {5'b0, ref_w}) ? d_q : {5'b0, ref_w};
	assign x_w    = cmd.chan ? p_q : 15'd16384 - p_q;
	assign diff_w = {1'b0, prev_q} - {1'b0, d_q};

	always_comb begin
		mul_a = 26'sd0;
		mul_b = 19'sd0;
		case (cmd.op)
			OP_T2:    begin mul_a = {11'b0, t_q};   mul_b = {4'b0, t_q}; end
			OP_T4:    begin mul_a = {11'b0, t2_q};  mul_b = {4'b0, t2_q}; end
			OP_G:     begin mul_a = {11'b0, g0_q};  mul_b = {4'b0, win_q}; end
			OP_VOL:   begin mul_a = {8'b0, g_q};    mul_b = {2'b0, cfg.volume}; end
			OP_HOP:   begin mul_a = {8'b0, g_q};    mul_b = {4'b0, cfg.hop_transmission}; end
			OP_PAN:   begin
				mul_a = {{10{side_q[15]}}, side_q};
				mul_b = {4'b0, cfg.panning_amount};
			end
			OP_X2:    begin mul_a = {11'b0, x_w};   mul_b = {4'b0, x_w}; end
			OP_R1:    begin mul_a = 26'sd77;        mul_b = {4'b0, x2_q}; end
			OP_R2,
			OP_R3:    begin mul_a = {11'b0, r_q};   mul_b = {4'b0, x2_q}; end
			OP_S:     begin mul_a = {11'b0, r_q};   mul_b = {4'b0, x_w}; end
			OP_GAIN:  begin mul_a = {8'b0, g_q};    mul_b = {4'b0, s_q}; end
			OP_CLOSE: begin mul_a = {{7{diff_w[18]}}, diff_w}; mul_b = 19'sd60; end
			OP_TERM:  begin mul_a = closing_q;      mul_b = {2'b0, cfg.doppler_amount}; end
			OP_PITCH: begin mul_a = {9'b0, cfg.base_pitch}; mul_b = {3'b0, f_q}; end
			default:  begin mul_a = 26'sd0;         mul_b = 19'sd0; end
		endcase
	end

	assign prod_w  = 45'(mul_a) * 45'(mul_b);
	assign sh_w    = prod_w >>> 14;
	// Signed quotients by 16384 round toward zero, so bias negatives first.
	assign trunc_w = (prod_w + (prod_w[44] ? 45'sd16383 : 45'sd0)) >>> 14;
	assign den_w   = $signed({28'd0, SPEED_Q8}) - trunc_w;
	assign gain_w  = sh_w[18:0];

	always_comb begin
		if (trunc_w > 45'sd16384)
			pan_c = 17'sd16384;
		else if (trunc_w < -45'sd16384)
			pan_c = -17'sd16384;
		else
			pan_c = trunc_w[16:0];
		psum = pan_c + 17'sd16384;
		pv   = dop_en_q ? sh_w[17:0] : {1'b0, cfg.base_pitch};
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = 32'd0;
		div_divisor  = 28'd1;
		case (cmd.op)
			OP_G0_GO: begin
				div_start    = 1'b1;
				div_dividend = {5'b0, ref_w, 14'b0};
				div_divisor  = {10'b0, dd_w};
			end
			OP_T_GO: begin
				div_start    = 1'b1;
				div_dividend = {d_q, 14'b0};
				div_divisor  = {11'b0, maxd_w};
			end
			OP_F_GO: begin
				div_start    = 1'b1;
				div_dividend = SPEED_SHIFTED;
				div_divisor  = {1'b0, den_q};
			end
			default: begin
				div_start    = 1'b0;
				div_dividend = 32'd0;
				div_divisor  = 28'd1;
			end
		endcase
	end

	ssvgp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quo)
	);

	assign stat.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			dop_en_q <= 1'b0;
		end else if (cmd.load) begin
			seen_q   <= 1'b1;
			dop_en_q <= seen_q && (cfg.doppler_amount != 17'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q    <= path_distance;
			prev_q <= previous_distance;
			hop_q  <= hop_count;
			side_q <= side_cosine;
		end
		case (cmd.op)
			OP_G0_WAIT: if (div_done) g0_q <= quo[14:0];
			OP_T_WAIT:  if (div_done) t_q <= quo[14:0];
			OP_T2:      t2_q <= sh_w[14:0];
			OP_T4:      win_q <= (sh_w[16:0] >= 17'd16384) ? 15'd0 : 15'd16384 - sh_w[14:0];
			OP_G:       g_q <= far_w ? 18'd0 : {3'b0, sh_w[14:0]};
			OP_VOL:     g_q <= sh_w[17:0];
			OP_HOP:     if (hop_q) g_q <= sh_w[17:0];
			OP_PAN:     p_q <= psum[15:1];
			OP_X2:      x2_q <= sh_w[14:0];
			OP_R1:      r_q <= 15'd1306 - sh_w[14:0];
			OP_R2:      r_q <= 15'd10584 - sh_w[14:0];
			OP_R3:      r_q <= 15'd25736 - sh_w[14:0];
			OP_S:       s_q <= (sh_w[14:0] > 15'd16384) ? 15'd16384 : sh_w[14:0];
			OP_GAIN: begin
				if (cmd.chan)
					gr_q <= (gain_w > 19'd65536) ? 17'd65536 : gain_w[16:0];
				else
					gl_q <= (gain_w > 19'd65536) ? 17'd65536 : gain_w[16:0];
			end
			OP_CLOSE:   closing_q <= prod_w[25:0];
			OP_TERM:    den_q <= (den_w < 45'sd256) ? 27'd256 : den_w[26:0];
			OP_F_WAIT: begin
				if (div_done) begin
					if (quo < 32'd8192)
						f_q <= 16'd8192;
					else if (quo > 32'd32768)
						f_q <= 16'd32768;
					else
						f_q <= quo[15:0];
				end
			end
			OP_PITCH: begin
				if (pv < 18'd2048)
					pitch_q <= 18'd2048;
				else if (pv > 18'd131072)
					pitch_q <= 18'd131072;
				else
					pitch_q <= pv;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			gl_out_q    <= gl_q;
			gr_out_q    <= gr_q;
			pitch_out_q <= pitch_q;
		end
	end

	assign gain_left  = gl_out_q;
	assign gain_right = gr_out_q;
	assign pitch_out  = pitch_out_q;

endmodule

// File: rtl/ssvgp_ctrl.sv
// Controller state machine: steps the datapath through one item.
// Depends on ssvgp_pkg for state, command and status types.
module ssvgp_ctrl import ssvgp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	st_t  state_q, state_d;
	logic chan_q;
	logic out_valid_q;
	logic out_load;

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_G0_GO;
			ST_G0_GO:   state_d = ST_G0_WAIT;
			ST_G0_WAIT: if (stat.div_done) state_d = ST_T_GO;
			ST_T_GO:    state_d = ST_T_WAIT;
			ST_T_WAIT:  if (stat.div_done) state_d = ST_T2;
			ST_T2:      state_d = ST_T4;
			ST_T4:      state_d = ST_G;
			ST_G:       state_d = ST_VOL;
			ST_VOL:     state_d = ST_HOP;
			ST_HOP:     state_d = ST_PAN;
			ST_PAN:     state_d = ST_X2;
			ST_X2:      state_d = ST_R1;
			ST_R1:      state_d = ST_R2;
			ST_R2:      state_d = ST_R3;
			ST_R3:      state_d = ST_S;
			ST_S:       state_d = ST_GAIN;
			// The sine chain runs once for the left and once for the right gain.
			ST_GAIN:    state_d = chan_q ? ST_CLOSE : ST_X2;
			ST_CLOSE:   state_d = ST_TERM;
			ST_TERM:    state_d = ST_F_GO;
			ST_F_GO:    state_d = ST_F_WAIT;
			ST_F_WAIT:  if (stat.div_done) state_d = ST_PITCH;
			ST_PITCH:   state_d = ST_DONE;
			ST_DONE:    if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.chan     = chan_q;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.out_load = out_load;
		unique case (state_q)
			ST_G0_GO:   cmd.op = OP_G0_GO;
			ST_G0_WAIT: cmd.op = OP_G0_WAIT;
			ST_T_GO:    cmd.op = OP_T_GO;
			ST_T_WAIT:  cmd.op = OP_T_WAIT;
			ST_T2:      cmd.op = OP_T2;
			ST_T4:      cmd.op = OP_T4;
			ST_G:       cmd.op = OP_G;
			ST_VOL:     cmd.op = OP_VOL;
			ST_HOP:     cmd.op = OP_HOP;
			ST_PAN:     cmd.op = OP_PAN;
			ST_X2:      cmd.op = OP_X2;
			ST_R1:      cmd.op = OP_R1;
			ST_R2:      cmd.op = OP_R2;
			ST_R3:      cmd.op = OP_R3;
			ST_S:       cmd.op = OP_S;
			ST_GAIN:    cmd.op = OP_GAIN;
			ST_CLOSE:   cmd.op = OP_CLOSE;
			ST_TERM:    cmd.op = OP_TERM;
			ST_F_GO:    cmd.op = OP_F_GO;
			ST_F_WAIT:  cmd.op = OP_F_WAIT;
			ST_PITCH:   cmd.op = OP_PITCH;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				chan_q <= 1'b0;
			else if (state_q == ST_GAIN)
				chan_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
